// ----- rtl/core/dsfd_pkg.sv -----
// package: constants, register indexes and control types for the dle frame deframer
package dsfd_pkg;

    localparam int FRAME_LEN    = 24;
    localparam int BUFFER_DEPTH = 64;

    localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int BYTE_W = 8;
    localparam bit FRAME_OK = (FRAME_LEN < BUFFER_DEPTH);

    localparam logic [ADDR_W-1:0] LAST_IDX  = ADDR_W'(FRAME_LEN - 1);
    localparam logic [ADDR_W-1:0] FULL_IDX  = ADDR_W'(BUFFER_DEPTH - 1);
    localparam logic [ADDR_W-1:0] MATCH_IDX = ADDR_W'(FRAME_LEN);

    localparam logic [0:0] CFG_ESCAPE_CHAR = 1'b0;
    localparam logic [0:0] CFG_END_CHAR    = 1'b1;

    localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'h10;
    localparam logic [BYTE_W-1:0] END_RESET    = 8'h03;

    typedef struct packed {
        logic store;
        logic clear_fill;
        logic rd_start;
        logic rd_issue;
    } dsfd_cmd_t;

    typedef struct packed {
        logic is_esc;
        logic is_end;
        logic fill_full;
        logic len_ok;
        logic rd_last;
        logic rd_slot;
    } dsfd_status_t;

endpackage

// ----- rtl/core/dsfd_ram.sv -----
// generic single write port ram with registered read
module dsfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/dsfd_ctrl.sv -----
// controller: parse phase state machine and readout sequencing
module dsfd_ctrl
    import dsfd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  dsfd_status_t st,
    output dsfd_cmd_t    cmd
);

    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_ESC  = 2'd2;
    localparam logic [1:0] PH_READ = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign s_ready = (state_reg != PH_READ);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            PH_WAIT: begin
                if (accept && st.is_esc) begin
                    cmd.clear_fill = 1'b1;
                    state_next     = PH_DATA;
                end
            end
            PH_DATA: begin
                if (accept) begin
                    if (st.is_esc) begin
                        state_next = PH_ESC;
                    end else begin
                        cmd.store = 1'b1;
                        if (st.fill_full) begin
                            cmd.clear_fill = 1'b1;
                            state_next     = PH_WAIT;
                        end
                    end
                end
            end
            PH_ESC: begin
                if (accept) begin
                    priority if (st.is_esc) begin
                        cmd.store  = 1'b1;
                        state_next = PH_DATA;
                        if (st.fill_full) begin
                            cmd.clear_fill = 1'b1;
                            state_next     = PH_WAIT;
                        end
                    end else if (st.is_end) begin
                        if (st.len_ok) begin
                            cmd.rd_start = 1'b1;
                            state_next   = PH_READ;
                        end else begin
                            state_next = PH_WAIT;
                        end
                    end else begin
                        cmd.clear_fill = 1'b1;
                        state_next     = PH_WAIT;
                    end
                end
            end
            PH_READ: begin
                if (st.rd_slot) begin
                    cmd.rd_issue = 1'b1;
                    if (st.rd_last) begin
                        state_next = PH_WAIT;
                    end
                end
            end
            default: begin
                state_next = PH_WAIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= PH_WAIT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/core/dsfd_dpath.sv -----
// datapath: delimiter registers, fill count, payload buffer and output register
module dsfd_dpath
    import dsfd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [BYTE_W-1:0] s_rx_byte,
    input  logic              cfg_valid,
    input  logic [0:0]        cfg_index,
    input  logic [BYTE_W-1:0] cfg_data,
    input  dsfd_cmd_t         cmd,
    output dsfd_status_t      st,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_frame_byte,
    output logic              m_last_byte
);

    logic [BYTE_W-1:0] escape_reg;
    logic [BYTE_W-1:0] end_reg;
    logic [ADDR_W-1:0] fill_reg;
    logic [ADDR_W-1:0] fill_next;
    logic [ADDR_W-1:0] rd_idx_reg;
    logic [ADDR_W-1:0] rd_idx_next;
    logic              rd_pend_reg;
    logic              rd_pend_next;
    logic              pend_last_reg;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [BYTE_W-1:0] m_byte_reg;
    logic              m_last_reg;
    logic [BYTE_W-1:0] ram_q;
    logic              load;

    assign st.is_esc    = (s_rx_byte == escape_reg);
    assign st.is_end    = (s_rx_byte == end_reg);
    assign st.fill_full = (fill_reg == FULL_IDX);
    assign st.len_ok    = FRAME_OK && (fill_reg == MATCH_IDX);
    assign st.rd_last   = (rd_idx_reg == LAST_IDX);

    assign load       = rd_pend_reg && (!m_valid_reg || m_ready);
    assign st.rd_slot = !rd_pend_reg || load;

    dsfd_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(BUFFER_DEPTH)
    ) u_buf (
        .aclk    (aclk),
        .wr_en   (cmd.store),
        .wr_addr (fill_reg),
        .wr_data (s_rx_byte),
        .rd_en   (cmd.rd_issue),
        .rd_addr (rd_idx_reg),
        .rd_data (ram_q)
    );

    always_comb begin
        fill_next = fill_reg;
        if (cmd.clear_fill) begin
            fill_next = '0;
        end else if (cmd.store) begin
            fill_next = fill_reg + ADDR_W'(1);
        end
        rd_idx_next = rd_idx_reg;
        if (cmd.rd_start) begin
            rd_idx_next = '0;
        end else if (cmd.rd_issue) begin
            rd_idx_next = rd_idx_reg + ADDR_W'(1);
        end
        rd_pend_next = rd_pend_reg;
        if (cmd.rd_issue) begin
            rd_pend_next = 1'b1;
        end else if (load) begin
            rd_pend_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            escape_reg  <= ESCAPE_RESET;
            end_reg     <= END_RESET;
            fill_reg    <= '0;
            rd_idx_reg  <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_ESCAPE_CHAR: escape_reg <= cfg_data;
                    CFG_END_CHAR:    end_reg    <= cfg_data;
                    default:         ;
                endcase
            end
            fill_reg    <= fill_next;
            rd_idx_reg  <= rd_idx_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_issue) begin
            pend_last_reg <= st.rd_last;
        end
        if (load) begin
            m_byte_reg <= ram_q;
            m_last_reg <= pend_last_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_frame_byte = m_byte_reg;
    assign m_last_byte  = m_last_reg;

endmodule

// ----- rtl/core/dle_stuffed_frame_deframer.sv -----
// top level: dle/etx byte stuffed frame deframer
// readout: FRAME_LEN bytes once the closing end delimiter is taken, with input held off meanwhile
// throughput: one received byte per cycle while parsing a frame
// readout: one byte per cycle unless m_ready stalls, from the single buffer read port
// reset: synchronous active low, clears parse phase, fill count, read pointer and output valid
// reset: payload buffer is not cleared, delimiters return to 0x10 and 0x03
module dle_stuffed_frame_deframer
    import dsfd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_rx_byte,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [0:0]        cfg_index,
    input  logic [BYTE_W-1:0] cfg_data,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_frame_byte,
    output logic              m_last_byte
);

    dsfd_cmd_t    cmd;
    dsfd_status_t st;

    assign cfg_ready = 1'b1;

    dsfd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    dsfd_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_rx_byte    (s_rx_byte),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .st           (st),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_byte (m_frame_byte),
        .m_last_byte  (m_last_byte)
    );

`ifndef ASSERT_OFF
    a_read_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_issue |-> !s_ready)
        else $error("buffer read issued while input request open");

    a_start_needs_length: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_start |-> (st.len_ok && st.is_end))
        else $error("readout started on wrong frame length");

    a_store_not_reading: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.store && cmd.rd_issue))
        else $error("store and readout in the same cycle");

    a_issue_has_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_issue |-> st.rd_slot)
        else $error("buffer read issued with no room downstream");
`endif

endmodule
